FILE: rtl/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and the saturation helper of the perspective
// matrix setup core.
// ----------------------------------------------------------------------------
package pms_pkg;

   // quotient bits produced by each divider; one more than the result width
   localparam int QUO_W = 33;

   // cot(22.5 deg) = 1 + sqrt(2), unsigned Q2.28
   localparam logic [29:0] COT_Q28 = 30'd648060519;

   localparam logic [32:0] NORM_LIMIT = 33'sd131072;
   localparam logic [15:0] NORM_MAX   = 16'hFFFF;
   localparam logic [15:0] NORM_MIN   = 16'h0001;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic        hit;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic        a_zero;
      logic        diff_zero;
      logic        sum_small;
      logic        x_neg;
      logic        d_neg;
      logic        o_neg;
      sat_type     ey;
      sat_type     ew;
   } side_type;

   // magnitude q with sign neg, clipped to 32-bit two's complement
   function automatic sat_type sat33(input logic neg, input logic ovf,
                                     input logic [QUO_W-1:0] q);
      sat_type r;
      if (!neg) begin
         r.hit = ovf || (q > {1'b0, POS_MAX});
         r.val = r.hit ? POS_MAX : q[31:0];
      end else begin
         r.hit = ovf || (q > {1'b0, NEG_MAX});
         r.val = r.hit ? NEG_MAX : (32'd0 - q[31:0]);
      end
      return r;
   endfunction

endpackage

FILE: rtl/pms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_div
// Pipelined restoring divider, one quotient bit per stage. Gives the low
// QUO_W quotient bits and an overflow flag when the quotient needs more.
// ----------------------------------------------------------------------------
module pms_div #(
   parameter int NW = 64,
   parameter int DW = 33
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [NW-1:0]            num_in,
   input  logic [DW-1:0]            den_in,
   output logic [pms_pkg::QUO_W-1:0] quo_out,
   output logic                     ovf_out
);
   import pms_pkg::*;

   localparam int HW = NW - QUO_W;
   localparam int CW = ((HW > DW) ? HW : DW) + 1;

   logic [DW-1:0]    rem_ff [QUO_W];
   logic [DW-1:0]    den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] ovf_ff;

   logic [CW-1:0]    hi_x;
   logic [CW-1:0]    den_x;
   logic             ovf_in;
   logic [DW:0]      step0;

   function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                            input logic b,
                                            input logic [DW-1:0] den);
      logic [DW:0] r2;
      r2 = {rem, b};
      if (r2 >= {1'b0, den}) begin
         r2 = r2 - {1'b0, den};
         return {1'b1, r2[DW-1:0]};
      end
      return {1'b0, r2[DW-1:0]};
   endfunction

   always_comb begin
      hi_x   = CW'(num_in[NW-1:QUO_W]);
      den_x  = CW'(den_in);
      ovf_in = hi_x >= den_x;
      step0  = div_step(hi_x[DW-1:0], num_in[QUO_W-1], den_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= step0[DW-1:0];
         quo_ff[0] <= QUO_W'(step0[DW]);
         low_ff[0] <= num_in[QUO_W-1:0];
         den_ff[0] <= den_in;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar j = 1; j < QUO_W; j++) begin : g_stage
      logic [DW:0] step_in;
      assign step_in = div_step(rem_ff[j-1], low_ff[j-1][QUO_W-1-j], den_ff[j-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= step_in[DW-1:0];
            quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], step_in[DW]};
            low_ff[j] <= low_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];
   assign ovf_out = ovf_ff[QUO_W-1];

endmodule

FILE: rtl/perspective_matrix_setup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_matrix_setup_core
// Fixed-point perspective projection matrix setup: five s15.16 elements,
// the 16-bit perspective normalizer and a degenerate flag per item.
// Pipeline: 38 register stages (4 operand/multiply, 33 divider stages of one
// quotient bit each, 1 output register) lie between the accepting edge and
// rsp_valid.
// Throughput: one item per cycle; the pipeline stalls only when its last
// stage and the output register are both full and rsp_ready is low.
// Reset: synchronous, active high; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module perspective_matrix_setup_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [31:0] req_aspect_ratio,
   input  logic signed [31:0] req_near_plane,
   input  logic signed [31:0] req_far_plane,
   input  logic signed [31:0] req_scale_factor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_elem_x_scale,
   output logic signed [31:0] rsp_elem_y_scale,
   output logic signed [31:0] rsp_elem_depth_scale,
   output logic signed [31:0] rsp_elem_w_select,
   output logic signed [31:0] rsp_elem_depth_offset,
   output logic        [15:0] rsp_persp_norm,
   output logic               rsp_degenerate
);
   import pms_pkg::*;

   logic adv;

   // stage 1: operand decode
   logic        v1_ff;
   logic [43:0] a_sh1_ff;
   logic        a_zero1_ff;
   logic [31:0] sm1_ff, nm1_ff, fm1_ff;
   logic        sneg1_ff, d_neg1_ff, o_neg1_ff;
   logic [32:0] sum1_ff, sum_m1_ff, diff_m1_ff;
   logic        diff_zero1_ff, sum_small1_ff;

   logic [32:0] sum_in, diff_in;

   always_comb begin
      sum_in  = {req_near_plane[31], req_near_plane} + {req_far_plane[31], req_far_plane};
      diff_in = {req_near_plane[31], req_near_plane} - {req_far_plane[31], req_far_plane};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         a_sh1_ff      <= {req_aspect_ratio, 12'd0};
         a_zero1_ff    <= req_aspect_ratio == 32'd0;
         sm1_ff        <= req_scale_factor[31] ? 32'd0 - req_scale_factor : req_scale_factor;
         nm1_ff        <= req_near_plane[31] ? 32'd0 - req_near_plane : req_near_plane;
         fm1_ff        <= req_far_plane[31] ? 32'd0 - req_far_plane : req_far_plane;
         sneg1_ff      <= req_scale_factor[31];
         d_neg1_ff     <= sum_in[32] ^ diff_in[32] ^ req_scale_factor[31];
         o_neg1_ff     <= req_near_plane[31] ^ req_far_plane[31] ^ diff_in[32]
                          ^ req_scale_factor[31];
         sum1_ff       <= sum_in;
         sum_m1_ff     <= sum_in[32] ? 33'd0 - sum_in : sum_in;
         diff_m1_ff    <= diff_in[32] ? 33'd0 - diff_in : diff_in;
         diff_zero1_ff <= diff_in == 33'd0;
         sum_small1_ff <= $signed(sum_in) <= $signed(NORM_LIMIT);
      end
   end

   // stage 2: first products
   logic        v2_ff;
   logic [61:0] prod_cs2_ff;
   logic [64:0] prod_ss2_ff;
   logic [63:0] prod_nf2_ff;
   logic [31:0] sm2_ff;
   sat_type     ew2_ff;
   logic [43:0] a_sh2_ff;
   logic        a_zero2_ff, sneg2_ff, d_neg2_ff, o_neg2_ff;
   logic [32:0] sum2_ff, diff_m2_ff;
   logic        diff_zero2_ff, sum_small2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         prod_cs2_ff   <= COT_Q28 * sm1_ff;
         prod_ss2_ff   <= sum_m1_ff * sm1_ff;
         prod_nf2_ff   <= nm1_ff * fm1_ff;
         sm2_ff        <= sm1_ff;
         ew2_ff        <= sat33(!sneg1_ff, 1'b0, {1'b0, sm1_ff});
         a_sh2_ff      <= a_sh1_ff;
         a_zero2_ff    <= a_zero1_ff;
         sneg2_ff      <= sneg1_ff;
         d_neg2_ff     <= d_neg1_ff;
         o_neg2_ff     <= o_neg1_ff;
         sum2_ff       <= sum1_ff;
         diff_m2_ff    <= diff_m1_ff;
         diff_zero2_ff <= diff_zero1_ff;
         sum_small2_ff <= sum_small1_ff;
      end
   end

   // stage 3: split product n*f*s
   logic        v3_ff;
   logic [61:0] prod_cs3_ff;
   logic [63:0] prod_ss3_ff;
   logic [63:0] pq_lo3_ff, pq_hi3_ff;
   side_type    side3_ff;
   logic [43:0] a_sh3_ff;
   logic [32:0] sum3_ff, diff_m3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         prod_cs3_ff        <= prod_cs2_ff;
         prod_ss3_ff        <= prod_ss2_ff[63:0];
         pq_lo3_ff          <= prod_nf2_ff[31:0] * sm2_ff;
         pq_hi3_ff          <= prod_nf2_ff[63:32] * sm2_ff;
         side3_ff.a_zero    <= a_zero2_ff;
         side3_ff.diff_zero <= diff_zero2_ff;
         side3_ff.sum_small <= sum_small2_ff;
         side3_ff.x_neg     <= sneg2_ff;
         side3_ff.d_neg     <= d_neg2_ff;
         side3_ff.o_neg     <= o_neg2_ff;
         side3_ff.ey        <= sat33(sneg2_ff, 1'b0, prod_cs2_ff[60:28]);
         side3_ff.ew        <= ew2_ff;
         a_sh3_ff           <= a_sh2_ff;
         sum3_ff            <= sum2_ff;
         diff_m3_ff         <= diff_m2_ff;
      end
   end

   // stage 4: divider operands
   logic        v4_ff;
   logic [61:0] num_x4_ff;
   logic [63:0] num_d4_ff;
   logic [95:0] num_o4_ff;
   logic [43:0] den_x4_ff;
   logic [32:0] den_d4_ff, den_n4_ff;
   logic [48:0] den_o4_ff;
   side_type    side4_ff;
   logic [95:0] num_o_in;

   assign num_o_in = {pq_hi3_ff, 32'd0} + {32'd0, pq_lo3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         num_x4_ff <= prod_cs3_ff;
         num_d4_ff <= prod_ss3_ff;
         num_o4_ff <= {num_o_in[94:0], 1'b0};
         den_x4_ff <= a_sh3_ff;
         den_d4_ff <= diff_m3_ff;
         den_o4_ff <= {diff_m3_ff, 16'd0};
         den_n4_ff <= sum3_ff;
         side4_ff  <= side3_ff;
      end
   end

   // divider stages
   logic [QUO_W-1:0] quo_x, quo_d, quo_o, quo_n;
   logic             ovf_x, ovf_d, ovf_o, ovf_n;

   pms_div #(.NW(62), .DW(44)) u_div_x (
      .clock(clock), .en(adv), .num_in(num_x4_ff), .den_in(den_x4_ff),
      .quo_out(quo_x), .ovf_out(ovf_x));

   pms_div #(.NW(64), .DW(33)) u_div_d (
      .clock(clock), .en(adv), .num_in(num_d4_ff), .den_in(den_d4_ff),
      .quo_out(quo_d), .ovf_out(ovf_d));

   pms_div #(.NW(96), .DW(49)) u_div_o (
      .clock(clock), .en(adv), .num_in(num_o4_ff), .den_in(den_o4_ff),
      .quo_out(quo_o), .ovf_out(ovf_o));

   pms_div #(.NW(34), .DW(33)) u_div_n (
      .clock(clock), .en(adv), .num_in(34'h2_0000_0000), .den_in(den_n4_ff),
      .quo_out(quo_n), .ovf_out(ovf_n));

   logic [QUO_W-1:0] dv_ff;
   side_type         dside_ff [QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[QUO_W-2:0], v4_ff};
      end
      if (adv) begin
         dside_ff[0] <= side4_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dside_ff[k] <= dside_ff[k-1];
         end
      end
   end

   // output register
   side_type    sd;
   sat_type     sx, sdp, so;
   logic [15:0] norm_in;
   logic        flag_in;
   logic        rsp_valid_ff;
   logic [31:0] ex_ff, ey_ff, ed_ff, ew_ff, eo_ff;
   logic [15:0] norm_ff;
   logic        flag_ff;

   always_comb begin
      sd  = dside_ff[QUO_W-1];
      sx  = sat33(sd.x_neg, ovf_x, quo_x);
      sdp = sat33(sd.d_neg, ovf_d, quo_d);
      so  = sat33(sd.o_neg, ovf_o, quo_o);
      if (sd.sum_small || ovf_n) begin
         norm_in = NORM_MAX;
      end else if (quo_n[15:0] == 16'd0) begin
         norm_in = NORM_MIN;
      end else begin
         norm_in = quo_n[15:0];
      end
      flag_in = sd.a_zero | sd.diff_zero | sd.ey.hit | sd.ew.hit
                | (!sd.a_zero & sx.hit) | (!sd.diff_zero & (sdp.hit | so.hit));
   end

   assign adv = !dv_ff[QUO_W-1] || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= dv_ff[QUO_W-1];
      end
      if (!rsp_valid_ff || rsp_ready) begin
         ex_ff   <= sd.a_zero ? 32'd0 : sx.val;
         ey_ff   <= sd.ey.val;
         ed_ff   <= sd.diff_zero ? 32'd0 : sdp.val;
         ew_ff   <= sd.ew.val;
         eo_ff   <= sd.diff_zero ? 32'd0 : so.val;
         norm_ff <= norm_in;
         flag_ff <= flag_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_elem_x_scale      = ex_ff;
   assign rsp_elem_y_scale      = ey_ff;
   assign rsp_elem_depth_scale  = ed_ff;
   assign rsp_elem_w_select     = ew_ff;
   assign rsp_elem_depth_offset = eo_ff;
   assign rsp_persp_norm        = norm_ff;
   assign rsp_degenerate        = flag_ff;

endmodule

FILE: rtl/pms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks of the perspective matrix setup core.
// ----------------------------------------------------------------------------
module pms_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_elem_x_scale,
   input logic [31:0] rsp_elem_w_select,
   input logic [15:0] rsp_persp_norm
);
   import pms_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elem_x_scale))
      else $error("result item changed while stalled");

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_persp_norm != 16'd0)
      else $error("normalizer is zero");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_elem_w_select != NEG_MAX)
      else $error("w select out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind perspective_matrix_setup_core pms_checker u_pms_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_elem_x_scale(rsp_elem_x_scale),
   .rsp_elem_w_select(rsp_elem_w_select),
   .rsp_persp_norm(rsp_persp_norm)
);

FILE: verif/perspective_matrix_setup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_matrix_setup_checker
// Watches the request and response channels of the matrix setup core. It
// computes the expected matrix elements, normalizer and flag for every
// accepted item, queues them in order and compares each returned item field
// by field.
// ----------------------------------------------------------------------------
module perspective_matrix_setup_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic        [31:0] req_aspect_ratio,
   input  logic signed [31:0] req_near_plane,
   input  logic signed [31:0] req_far_plane,
   input  logic signed [31:0] req_scale_factor,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_elem_x_scale,
   input  logic signed [31:0] rsp_elem_y_scale,
   input  logic signed [31:0] rsp_elem_depth_scale,
   input  logic signed [31:0] rsp_elem_w_select,
   input  logic signed [31:0] rsp_elem_depth_offset,
   input  logic        [15:0] rsp_persp_norm,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 pending,
   output int                 degenerate_seen,
   output int                 matrices_seen
);
   import pms_pkg::*;

   typedef struct packed {
      logic [31:0] x_scale;
      logic [31:0] y_scale;
      logic [31:0] depth_scale;
      logic [31:0] w_select;
      logic [31:0] depth_offset;
      logic [15:0] norm;
      logic        degenerate;
   } matrix_type;

   matrix_type expected_matrices[$];

   // returns {clipped, value}
   function automatic logic [32:0] clip_s32(input logic neg, input logic [127:0] q);
      if (!neg) begin
         if (q > {96'd0, POS_MAX}) return {1'b1, POS_MAX};
         return {1'b0, q[31:0]};
      end
      if (q > {96'd0, NEG_MAX}) return {1'b1, NEG_MAX};
      return {1'b0, 32'd0 - q[31:0]};
   endfunction

   function automatic logic [127:0] mag(input longint v);
      logic [63:0] u;
      u = v;
      if (v < 0) u = 64'd0 - u;
      return {64'd0, u};
   endfunction

   function automatic matrix_type compute_matrix(input logic [31:0] a,
                                                 input logic signed [31:0] n_in,
                                                 input logic signed [31:0] f_in,
                                                 input logic signed [31:0] s_in);
      longint n, f, s, sum, diff;
      logic [127:0] sm, cot, q;
      logic [32:0] c;
      logic sneg, flag, neg;
      matrix_type m;
      n = n_in; f = f_in; s = s_in;
      sum = n + f;
      diff = n - f;
      sm = mag(s);
      sneg = s < 0;
      cot = {98'd0, COT_Q28};
      flag = 1'b0;
      m = '0;

      if (a == 0) flag = 1'b1;
      else begin
         q = (cot * sm) / ({96'd0, a} << 12);
         c = clip_s32(sneg, q); flag |= c[32]; m.x_scale = c[31:0];
      end

      q = (cot * sm) >> 28;
      c = clip_s32(sneg, q); flag |= c[32]; m.y_scale = c[31:0];

      if (diff == 0) flag = 1'b1;
      else begin
         neg = (sum < 0) ^ ((diff < 0) ^ sneg);
         q = (mag(sum) * sm) / mag(diff);
         c = clip_s32(neg, q); flag |= c[32]; m.depth_scale = c[31:0];
         neg = ((n < 0) ^ (f < 0)) ^ ((diff < 0) ^ sneg);
         q = (mag(n) * mag(f) * (sm << 1)) / (mag(diff) << 16);
         c = clip_s32(neg, q); flag |= c[32]; m.depth_offset = c[31:0];
      end

      c = clip_s32(!sneg, sm); flag |= c[32]; m.w_select = c[31:0];

      if (sum <= 131072) m.norm = NORM_MAX;
      else begin
         q = (128'd1 << 33) / {64'd0, sum};
         m.norm = (q == 0) ? NORM_MIN : q[15:0];
      end
      m.degenerate = flag;
      return m;
   endfunction

   always @(posedge clock) begin
      matrix_type want, got;
      if (reset) begin
         fail_count <= 0;
         degenerate_seen <= 0;
         matrices_seen <= 0;
         expected_matrices.delete();
      end else begin
         if (req_valid && req_ready)
            expected_matrices.push_back(compute_matrix(req_aspect_ratio, req_near_plane,
                                                       req_far_plane, req_scale_factor));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_elem_x_scale, rsp_elem_y_scale, rsp_elem_depth_scale,
                   rsp_elem_w_select, rsp_elem_depth_offset, rsp_persp_norm,
                   rsp_degenerate};
            matrices_seen <= matrices_seen + 1;
            if (rsp_degenerate) degenerate_seen <= degenerate_seen + 1;
            if (expected_matrices.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%0t: unexpected item %h", $realtime, got);
            end else begin
               want = expected_matrices.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("%0t: mismatch x %h/%h y %h/%h dz %h/%h w %h/%h", $realtime,
                              want.x_scale, got.x_scale, want.y_scale, got.y_scale,
                              want.depth_scale, got.depth_scale, want.w_select, got.w_select);
                     $display("   off %h/%h norm %h/%h degen %b/%b (exp/act)",
                              want.depth_offset, got.depth_offset, want.norm, got.norm,
                              want.degenerate, got.degenerate);
                  end
               end
            end
         end
      end
   end

   assign pending = expected_matrices.size();

endmodule

FILE: verif/perspective_matrix_setup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_matrix_setup_core_tb
// Drives directed corner items (zero aspect, equal planes, saturation,
// small sums) and then random and realistic view setups through the core
// under varying request gaps and response stalls, including one long stall.
// ----------------------------------------------------------------------------
module perspective_matrix_setup_core_tb;
   import pms_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, req_ready, rsp_valid, rsp_ready = 1'b0;
   logic [31:0] req_aspect_ratio = '0;
   logic signed [31:0] req_near_plane = '0, req_far_plane = '0, req_scale_factor = '0;
   logic signed [31:0] rsp_elem_x_scale, rsp_elem_y_scale, rsp_elem_depth_scale;
   logic signed [31:0] rsp_elem_w_select, rsp_elem_depth_offset;
   logic [15:0] rsp_persp_norm;
   logic rsp_degenerate;
   int fail_count, pending, degenerate_seen, matrices_seen;
   int send_idle_pct = 0, stall_pct = 0, hold_req = 0, hold_done = 0, hold_left = 0;
   int quiet_cycles = 0, items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   perspective_matrix_setup_core uut (.*);
   perspective_matrix_setup_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= hold_req;
      end else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else if (pending > 0 || req_valid) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog timeout, %0d items outstanding", pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(input logic [31:0] a, input logic [31:0] n,
                            input logic [31:0] f, input logic [31:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_aspect_ratio <= a;
      req_near_plane <= n;
      req_far_plane <= f;
      req_scale_factor <= s;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_s1616(input int lo, input int hi);
      return $urandom_range(hi, lo) * 256 + $urandom_range(255);
   endfunction

   task automatic random_item();
      logic [31:0] a, n, f, s;
      int pick;
      pick = $urandom_range(9);
      a = $urandom; n = $urandom; f = $urandom; s = $urandom;
      if (pick < 6) begin
         // plausible camera: aspect 0.5..4, near 0.01..16, far up to 4096, scale near 1
         a = rand_s1616(128, 1024);
         n = $urandom_range(4096, 600) + ($urandom_range(1) ? 0 : $urandom_range(1 << 20));
         f = n + $urandom_range(1 << 28, 1);
         s = $urandom_range(1 << 18, 1 << 14);
         if ($urandom_range(1)) s = -s;
         if ($urandom_range(3) == 0) {n, f} = {f, n};
      end else if (pick == 6) begin
         f = n;
      end else if (pick == 7) begin
         a = $urandom_range(3);
         s = $urandom_range(1) ? 32'h8000_0000 : s;
      end else if (pick == 8) begin
         n = $urandom_range(131072); f = 131072 - n + $urandom_range(2) - 1;
      end
      send_item(a, n, f, s);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) random_item();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(32'h0001_0000, 32'h0000_0100, 32'h0064_0000, 32'h0001_0000);
      send_item(32'h0000_0000, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000);
      send_item(32'h0000_0001, 32'h0001_0000, 32'h0010_0000, 32'h7FFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0001_0000, 32'h0010_0000, 32'h8000_0000);
      send_item(32'h0001_0000, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
      send_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
      send_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h0000_0001, 32'h0002_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'hFFF0_0000, 32'hFFE0_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h4000_0000, 32'h4000_0000, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
      send_item(32'h0001_5555, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_item(32'h8000_0000, 32'h0000_199A, 32'h03E8_0000, 32'h0002_0000);
      send_item(32'h0000_0001, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

      run_phase(0, 0, 90);
      run_phase(86, 0, 70);
      run_phase(0, 86, 70);
      run_phase(38, 38, 70);
      hold_req = 1;
      run_phase(0, 0, 80);
      run_phase(20, 20, 50);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("sent %0d items, checked %0d matrices, %0d flagged degenerate",
               items_sent, matrices_seen, degenerate_seen);
      $display("phases: free flow, sparse requests, heavy stalls, mixed, long hold-off");
      if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
